FILE: sv/ltk_pkg.sv
// ltk_pkg: shared types, constants and helper functions for the lock-to-key encoder.
// No dependencies.
package ltk_pkg;

  localparam int MAX_LOCK  = 2048;
  localparam int CNT_W     = $clog2(MAX_LOCK + 1);
  localparam int KEY_IDX_W = 11;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int ESC_LEN   = 10;
  localparam int POS_W     = $clog2(ESC_LEN);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SHORT = 2'd1;
  localparam status_t ST_LONG  = 2'd2;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_DOLLAR  = 8'd36;

  // one request from the front: an optional key byte and an optional closing record
  typedef struct packed {
    logic                 has_key;
    logic [KEY_IDX_W-1:0] key_idx;
    logic [7:0]           key_val;
    logic                 key_esc;
    logic                 has_tail;
    logic [7:0]           tail_val;
    logic                 tail_esc;
    status_t              tail_status;
  } ltk_req_t;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  function automatic logic needs_escape(input logic [7:0] v);
    return (v == 8'd0) || (v == 8'd5) || (v == 8'd36) || (v == 8'd96) ||
           (v == 8'd124) || (v == 8'd126);
  endfunction

  // decimal digits of the escapable values, as {hundreds, tens, ones}
  function automatic logic [11:0] esc_digits(input logic [7:0] v);
    logic [11:0] d;
    case (v)
      8'd5:    d = {4'd0, 4'd0, 4'd5};
      8'd36:   d = {4'd0, 4'd3, 4'd6};
      8'd96:   d = {4'd0, 4'd9, 4'd6};
      8'd124:  d = {4'd1, 4'd2, 4'd4};
      8'd126:  d = {4'd1, 4'd2, 4'd6};
      default: d = 12'd0;
    endcase
    return d;
  endfunction

  // character at position pos of "/%DCNddd%/"
  function automatic logic [7:0] esc_char(input logic [7:0] v, input logic [POS_W-1:0] pos);
    logic [11:0] d;
    logic [7:0]  c;
    d = esc_digits(v);
    case (pos)
      POS_W'(0): c = CH_SLASH;
      POS_W'(1): c = CH_PERCENT;
      POS_W'(2): c = CH_D;
      POS_W'(3): c = CH_C;
      POS_W'(4): c = CH_N;
      POS_W'(5): c = CH_ZERO + {4'd0, d[11:8]};
      POS_W'(6): c = CH_ZERO + {4'd0, d[7:4]};
      POS_W'(7): c = CH_ZERO + {4'd0, d[3:0]};
      POS_W'(8): c = CH_PERCENT;
      default:   c = CH_SLASH;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/ltk_front.sv
// ltk_front: takes lock bytes, keeps the running lock state and forms key-byte requests.
// Depends on ltk_pkg.
module ltk_front import ltk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  lock_byte,
  input  logic        lock_end,
  input  logic [15:0] local_port,
  input  logic        q_full,
  output logic        q_push,
  output ltk_req_t    q_req
);

  logic [7:0]       first_lock_byte;
  logic [7:0]       previous_lock_byte;
  logic [CNT_W-1:0] byte_count;
  logic             overflow_seen;

  logic       accept;
  logic       drop;
  logic [7:0] key_raw;
  logic [7:0] port_mix;
  logic [7:0] k0_sw;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign drop     = overflow_seen || (byte_count >= CNT_W'(MAX_LOCK));
  assign key_raw  = lock_byte ^ previous_lock_byte;
  assign port_mix = local_port[7:0] + local_port[15:8];
  // key_raw is the newest key byte, the one key byte 0 folds in at lock end
  assign k0_sw    = swap_nibbles(first_lock_byte ^ key_raw ^ port_mix);

  always_comb begin
    q_req = '0;
    q_req.key_idx  = KEY_IDX_W'(byte_count);
    q_req.key_val  = swap_nibbles(key_raw);
    q_req.key_esc  = needs_escape(swap_nibbles(key_raw));
    q_req.tail_status = ST_OK;
    if (drop) begin
      q_req.has_tail    = lock_end;
      q_req.tail_status = ST_LONG;
    end else begin
      q_req.has_key  = (byte_count != '0);
      q_req.has_tail = lock_end;
      if (byte_count == '0) begin
        q_req.tail_status = ST_SHORT;
      end else begin
        q_req.tail_val = k0_sw;
        // key byte 0 equal to '$' goes out raw
        q_req.tail_esc = needs_escape(k0_sw) && (k0_sw != CH_DOLLAR);
      end
    end
  end

  assign q_push = accept && (q_req.has_key || q_req.has_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_lock_byte    <= '0;
      previous_lock_byte <= '0;
      byte_count         <= '0;
      overflow_seen      <= 1'b0;
    end else if (accept) begin
      if (lock_end) begin
        first_lock_byte    <= '0;
        previous_lock_byte <= '0;
        byte_count         <= '0;
        overflow_seen      <= 1'b0;
      end else if (drop) begin
        overflow_seen <= 1'b1;
      end else begin
        if (byte_count == '0) begin
          first_lock_byte <= lock_byte;
        end
        previous_lock_byte <= lock_byte;
        byte_count         <= byte_count + CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/ltk_queue.sv
// ltk_queue: short request queue between the front and the character sequencer.
// Depends on ltk_pkg.
module ltk_queue import ltk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ltk_req_t push_req,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output ltk_req_t head
);

  ltk_req_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/ltk_back.sv
// ltk_back: expands queued requests into registered key characters, one per unstalled cycle.
// Depends on ltk_pkg.
module ltk_back import ltk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  ltk_req_t             head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_IDX_W-1:0] key_index,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output status_t              status
);

  logic             seg_tail;
  logic [POS_W-1:0] pos;

  logic                 in_key;
  logic [7:0]           cur_val;
  logic                 cur_esc;
  logic [KEY_IDX_W-1:0] cur_idx;
  logic [7:0]           cur_char;
  logic                 seg_end;
  logic                 fire;

  assign in_key   = head.has_key && !seg_tail;
  assign cur_val  = in_key ? head.key_val : head.tail_val;
  assign cur_esc  = in_key ? head.key_esc : head.tail_esc;
  assign cur_idx  = in_key ? head.key_idx : '0;
  assign cur_char = cur_esc ? esc_char(cur_val, pos) : cur_val;
  assign seg_end  = !cur_esc || (pos == POS_W'(ESC_LEN - 1));
  assign fire     = head_valid && (!out_valid || out_ready);
  assign pop      = fire && seg_end && !(in_key && head.has_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_tail <= 1'b0;
      pos      <= '0;
    end else if (fire) begin
      if (seg_end) begin
        pos      <= '0;
        seg_tail <= in_key && head.has_tail;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_index <= cur_idx;
      out_char  <= cur_char;
      out_last  <= !in_key && seg_end;
      status    <= in_key ? ST_OK : head.tail_status;
    end
  end

endmodule

FILE: sv/lock_to_key_encoder_top.sv
// lock_to_key_encoder_top: lock-to-key encoder, front classifier, request queue, char sequencer.
// Depends on ltk_pkg, ltk_front, ltk_queue, ltk_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one lock byte per request; lock_end marks
//   the last byte, and local_port is sampled with it. Output channel (out_valid/out_ready)
//   carries one key character per request with its key_index, out_char, out_last and status.
//   Key byte i (i >= 1) streams out when lock byte i arrives; key byte 0 follows the
//   final byte and closes the key with out_last. Escaped bytes take ten characters.
//   A too-short or too-long lock ends with a single character 0 with status 1 or 2.
// Path: an accepted request is written into the queue and then, from the queue head, into
//   the output register, which holds while out_ready is low.
// Throughput: the front takes one byte per cycle while the 4-entry queue has room; the
//   sequencer emits one character per cycle while out_ready is high, one per raw byte,
//   ten per escaped byte, up to twenty for the final byte; the output sets the sustained rate.
// Reset: rst clears the lock state, the queue and the output valid; the block takes input
//   as soon as reset drops.
// Stall: when out_ready is low the output register holds; the queue absorbs up to four
//   requests before in_ready falls.
module lock_to_key_encoder_top import ltk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           lock_byte,
  input  logic                 lock_end,
  input  logic [15:0]          local_port,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_IDX_W-1:0] key_index,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output logic [1:0]           status
);

  logic     q_full;
  logic     q_push;
  ltk_req_t q_req;
  logic     q_pop;
  logic     q_head_valid;
  ltk_req_t q_head;

  ltk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lock_byte  (lock_byte),
    .lock_end   (lock_end),
    .local_port (local_port),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_req      (q_req)
  );

  ltk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_req   (q_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ltk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_index  (key_index),
    .out_char   (out_char),
    .out_last   (out_last),
    .status     (status)
  );

endmodule

FILE: sv/ltk_checker.sv
// ltk_checker: port-level assertions for the lock-to-key encoder, bound to the top level.
// Depends on ltk_pkg and lock_to_key_encoder_top.
module ltk_checker import ltk_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [KEY_IDX_W-1:0] key_index,
  input logic [7:0]           out_char,
  input logic                 out_last,
  input logic [1:0]           status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(key_index)
      && $stable(out_last) && $stable(status))
    else $error("output request changed while stalled");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> out_last)
    else $error("error status on a character that is not last");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (key_index == '0) && (out_char == 8'd0))
    else $error("error record with nonzero payload");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lock_to_key_encoder_top ltk_checker u_ltk_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_index (key_index),
  .out_char  (out_char),
  .out_last  (out_last),
  .status    (status)
);
